// ===== hdl/bounded_ordered_value_list_unit_defines.svh =====
// assertion macros for the bounded ordered value list unit
`ifndef BOUNDED_ORDERED_VALUE_LIST_UNIT_DEFINES_SVH
`define BOUNDED_ORDERED_VALUE_LIST_UNIT_DEFINES_SVH

// same-cycle implication
`define BOVL_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BOVL_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bovl_pkg.sv =====
// shared types and constants for the bounded ordered value list unit
`timescale 1ns / 1ps
package bovl_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int MODE_W         = 2;
   localparam int STATUS_W       = 2;
   localparam int LENGTH_W       = 5;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_TEST   = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH,
      ST_SHIFT
   } state_type;

endpackage

// ===== hdl/bounded_ordered_value_list_unit.sv =====
// top level of the bounded ordered value list unit
`timescale 1ns / 1ps
`include "bounded_ordered_value_list_unit_defines.svh"

// Ordered list of up to DEPTH values kept in a circular buffer (front pointer
// plus count) over a single-write, single-registered-read memory. An item is
// taken when start is high and busy is low; its one result appears for exactly
// one cycle with rsp_strobe, and there is no way to hold it off, so the
// receiver must take it on that cycle. Push, and any item refused because the
// list is full or empty, strobes the cycle after it is taken. Pop reads the
// front entry, then ST_POP registers its result. Delete and membership test
// walk the stored entries through the one read port and one shared
// comparator, one entry per cycle, second entry to last and then the front.
// A delete that hits an inner entry then closes the gap, one entry moved per
// cycle. busy stays high for the whole walk. After reset the list is empty
// and usable at once; no clearing pass is needed.
module bounded_ordered_value_list_unit #(
   parameter int DEPTH      = bovl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bovl_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bovl_pkg::MODE_W-1:0]       req_mode,
   input  logic [bovl_pkg::VALUE_W-1:0]      req_value,
   output logic                              rsp_strobe,
   output logic [bovl_pkg::VALUE_W-1:0]      rsp_popped_value,
   output logic                              rsp_found,
   output logic [bovl_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bovl_pkg::LENGTH_W-1:0]     rsp_length
);

   localparam int AW = $clog2(DEPTH);

   // memory port wires between sequencer and store
   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   // sequencer owns pointers, compare unit and the result register
   bovl_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_length       (rsp_length),
      .mem_wr_en        (mem_wr_en),
      .mem_wr_addr      (mem_wr_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_en        (mem_rd_en),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data)
   );

   // entry storage, contents undefined until written
   bovl_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // a push never walks the list: its result follows on the next cycle
   `BOVL_ASSERT_NEXT(a_push_one_cycle, clock, reset, start && !busy && req_mode == bovl_pkg::MODE_PUSH, rsp_strobe, "push result not on next cycle")

   // a match is only ever reported with ok status
   `BOVL_ASSERT_IMP(a_found_ok, clock, reset, rsp_strobe && rsp_found, rsp_status == bovl_pkg::STATUS_OK, "found with non-ok status")

   // a full refusal reports the list at capacity
   `BOVL_ASSERT_IMP(a_full_len, clock, reset, rsp_strobe && rsp_status == bovl_pkg::STATUS_FULL, rsp_length == bovl_pkg::LENGTH_W'(DEPTH), "full status with short length")

   // a walk never writes and reads the same entry in one cycle
   `BOVL_ASSERT_IMP(a_no_rw_clash, clock, reset, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write of one entry together")

endmodule

// ===== hdl/bovl_store.sv =====
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
module bovl_store #(
   parameter int DEPTH      = bovl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bovl_pkg::DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bovl_seq.sv =====
// sequencer: list pointers, shared compare unit and result register
`timescale 1ns / 1ps
module bovl_seq #(
   parameter int DEPTH      = bovl_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bovl_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bovl_pkg::MODE_W-1:0]       req_mode,
   input  logic [bovl_pkg::VALUE_W-1:0]      req_value,
   output logic                              rsp_strobe,
   output logic [bovl_pkg::VALUE_W-1:0]      rsp_popped_value,
   output logic                              rsp_found,
   output logic [bovl_pkg::STATUS_W-1:0]     rsp_status,
   output logic [bovl_pkg::LENGTH_W-1:0]     rsp_length,
   output logic                              mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
   output logic [DATA_WIDTH-1:0]             mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
   input  logic [DATA_WIDTH-1:0]             mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   // logical position to memory address, head plus offset with wrap
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] lpos);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, lpos};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   bovl_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   bovl_pkg::mode_type   mode_ff, mode_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [CW-1:0]        iss_ff, iss_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_pos_ff, rd_pos_in;
   logic                 rd_last_ff, rd_last_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic [bovl_pkg::VALUE_W-1:0]  rsp_popped_ff, rsp_popped_in;
   logic                          rsp_found_ff, rsp_found_in;
   bovl_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [bovl_pkg::LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   bovl_pkg::mode_type   req_mode_c;
   logic                 accept;
   logic                 cnt_zero;
   logic                 cnt_full;
   logic [CW-1:0]        cnt_m1;
   logic [AW-1:0]        head_inc;
   logic [AW-1:0]        head_dec;
   logic                 hit;
   logic                 rd_at_tail;
   logic                 search_end;
   logic [AW-1:0]        iss_lpos;

   assign req_mode_c = bovl_pkg::mode_type'(req_mode);
   assign accept     = start && (state_ff == bovl_pkg::ST_IDLE);
   assign cnt_zero   = (count_ff == '0);
   assign cnt_full   = (count_ff == DEPTH_C);
   assign cnt_m1     = count_ff - CW'(1);
   assign head_inc   = (head_ff == LAST_ADDR) ? '0 : head_ff + AW'(1);
   assign head_dec   = (head_ff == '0) ? LAST_ADDR : head_ff - AW'(1);
   // the one compare unit, shared by every step of a search
   assign hit        = rd_vld_ff && (mem_rd_data == key_ff);
   assign rd_at_tail = (CW'(rd_pos_ff) == cnt_m1);
   assign search_end = hit || (rd_vld_ff && rd_last_ff);
   // search order: second entry to last, then the front
   assign iss_lpos   = (iss_ff == count_ff) ? '0 : iss_ff[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bovl_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_mode_c) inside
                  bovl_pkg::MODE_PUSH: state_in = bovl_pkg::ST_IDLE;
                  bovl_pkg::MODE_POP: begin
                     if (!cnt_zero) state_in = bovl_pkg::ST_POP;
                  end
                  bovl_pkg::MODE_DELETE, bovl_pkg::MODE_TEST: begin
                     if (!cnt_zero) state_in = bovl_pkg::ST_SEARCH;
                  end
                  default: state_in = bovl_pkg::ST_IDLE;
               endcase
            end
         end
         bovl_pkg::ST_POP: state_in = bovl_pkg::ST_IDLE;
         bovl_pkg::ST_SEARCH: begin
            if (hit) begin
               if (mode_ff == bovl_pkg::MODE_DELETE && rd_pos_ff != '0 && !rd_at_tail) begin
                  state_in = bovl_pkg::ST_SHIFT;
               end else begin
                  state_in = bovl_pkg::ST_IDLE;
               end
            end else if (rd_vld_ff && rd_last_ff) begin
               state_in = bovl_pkg::ST_IDLE;
            end
         end
         bovl_pkg::ST_SHIFT: begin
            if (rd_vld_ff && rd_at_tail) state_in = bovl_pkg::ST_IDLE;
         end
         default: state_in = bovl_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      iss_in        = iss_ff;
      rd_vld_in     = 1'b0;
      rd_pos_in     = rd_pos_ff;
      rd_last_in    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = head_dec;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = head_ff;
      rsp_strobe_in = 1'b0;
      rsp_popped_in = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = bovl_pkg::STATUS_OK;

      unique case (state_ff)
         bovl_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = req_mode_c;
               key_in  = DATA_WIDTH'(req_value);
               iss_in  = CW'(1);
               unique case (req_mode_c) inside
                  bovl_pkg::MODE_PUSH: begin
                     rsp_strobe_in = 1'b1;
                     if (cnt_full) begin
                        rsp_status_in = bovl_pkg::STATUS_FULL;
                     end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = head_dec;
                        mem_wr_data = DATA_WIDTH'(req_value);
                        head_in     = head_dec;
                        count_in    = count_ff + CW'(1);
                     end
                  end
                  bovl_pkg::MODE_POP: begin
                     if (cnt_zero) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = bovl_pkg::STATUS_EMPTY;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = head_ff;
                        rd_vld_in   = 1'b1;
                     end
                  end
                  bovl_pkg::MODE_DELETE, bovl_pkg::MODE_TEST: begin
                     if (cnt_zero) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = bovl_pkg::STATUS_EMPTY;
                     end
                  end
                  default: rsp_strobe_in = 1'b0;
               endcase
            end
         end
         bovl_pkg::ST_POP: begin
            rsp_strobe_in = 1'b1;
            rsp_popped_in = bovl_pkg::VALUE_W'(mem_rd_data);
            head_in       = head_inc;
            count_in      = cnt_m1;
         end
         bovl_pkg::ST_SEARCH: begin
            if (hit) begin
               rsp_found_in = 1'b1;
               if (mode_ff == bovl_pkg::MODE_DELETE) begin
                  if (rd_pos_ff == '0) begin
                     // front entry goes: just move the front forward
                     rsp_strobe_in = 1'b1;
                     head_in       = head_inc;
                     count_in      = cnt_m1;
                  end else if (rd_at_tail) begin
                     rsp_strobe_in = 1'b1;
                     count_in      = cnt_m1;
                  end else begin
                     iss_in = CW'(rd_pos_ff) + CW'(1);
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end else if (rd_vld_ff && rd_last_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bovl_pkg::STATUS_MISSING;
            end else if (!search_end && iss_ff <= count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = phys(head_ff, iss_lpos);
               rd_vld_in   = 1'b1;
               rd_pos_in   = iss_lpos;
               rd_last_in  = (iss_ff == count_ff);
               iss_in      = iss_ff + CW'(1);
            end
         end
         bovl_pkg::ST_SHIFT: begin
            // close the gap: entry i+1 moves down to i
            if (rd_vld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = phys(head_ff, rd_pos_ff - AW'(1));
               mem_wr_data = mem_rd_data;
            end
            if (rd_vld_ff && rd_at_tail) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               count_in      = cnt_m1;
            end else if (iss_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = phys(head_ff, iss_ff[AW-1:0]);
               rd_vld_in   = 1'b1;
               rd_pos_in   = iss_ff[AW-1:0];
               iss_in      = iss_ff + CW'(1);
            end
         end
         default: rsp_strobe_in = 1'b0;
      endcase

      rsp_length_in = bovl_pkg::LENGTH_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bovl_pkg::ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      iss_ff        <= iss_in;
      rd_pos_ff     <= rd_pos_in;
      rd_last_ff    <= rd_last_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign busy             = (state_ff != bovl_pkg::ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_length       = rsp_length_ff;

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the bounded ordered value list unit
`timescale 1ns / 1ps

module tb_top;

   // list capacity as built into the unit under test
   localparam int LIST_DEPTH  = bovl_pkg::DEPTH_DEF;
   // cycles with nothing taken or returned before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   // random items after the directed table
   localparam int RANDOM_ITEMS = 800;

   // one result item, field by field
   typedef struct packed {
      logic [bovl_pkg::VALUE_W-1:0]  popped_value;
      logic                          found;
      bovl_pkg::status_type          status;
      logic [bovl_pkg::LENGTH_W-1:0] length;
   } list_result_type;

   // one directed row: operation, value, repeat count (value steps by one
   // per repeat) and, where it is obvious, the result typed in by hand
   typedef struct {
      bovl_pkg::mode_type           op;
      logic [bovl_pkg::VALUE_W-1:0] value;
      int                           reps;
      bit                           typed;
      list_result_type              want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [bovl_pkg::MODE_W-1:0]   req_mode;
   logic [bovl_pkg::VALUE_W-1:0]  req_value;
   logic                          rsp_strobe;
   logic [bovl_pkg::VALUE_W-1:0]  rsp_popped_value;
   logic                          rsp_found;
   logic [bovl_pkg::STATUS_W-1:0] rsp_status;
   logic [bovl_pkg::LENGTH_W-1:0] rsp_length;

   // predictor state: the stored values, front at index zero
   logic [bovl_pkg::VALUE_W-1:0] list_model[$];
   // results still owed by the unit, oldest first
   list_result_type              owed_results[$];
   // hand-typed expectation for the item currently on the request ports
   bit                           typed_valid;
   list_result_type              typed_result;
   int                           mismatches;
   int                           stall_cycles;

   // directed part: empty list errors, extreme values, fill to capacity,
   // push when full, delete order with a duplicate at the front, drain
   stim_row_type directed_rows [19] = '{
      '{bovl_pkg::MODE_POP, 32'h0000_0000, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_EMPTY, 5'd0}},
      '{bovl_pkg::MODE_DELETE, 32'h0000_0005, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_EMPTY, 5'd0}},
      '{bovl_pkg::MODE_TEST, 32'h0000_0005, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_EMPTY, 5'd0}},
      '{bovl_pkg::MODE_PUSH, 32'h0000_0000, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_OK, 5'd1}},
      '{bovl_pkg::MODE_PUSH, 32'hFFFF_FFFF, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_OK, 5'd2}},
      '{bovl_pkg::MODE_TEST,   32'h0000_0000, 1,  1'b0, '0},
      '{bovl_pkg::MODE_TEST, 32'h1234_5678, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_MISSING, 5'd2}},
      '{bovl_pkg::MODE_DELETE, 32'h1234_5678, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_MISSING, 5'd2}},
      '{bovl_pkg::MODE_POP, 32'h0000_0000, 1, 1'b1,
        '{32'hFFFF_FFFF, 1'b0, bovl_pkg::STATUS_OK, 5'd1}},
      '{bovl_pkg::MODE_PUSH,   32'h8000_0000, 15, 1'b0, '0},
      '{bovl_pkg::MODE_PUSH, 32'h5A5A_5A5A, 1, 1'b1,
        '{32'h0, 1'b0, bovl_pkg::STATUS_FULL, 5'd16}},
      '{bovl_pkg::MODE_DELETE, 32'h8000_0005, 1,  1'b0, '0},
      '{bovl_pkg::MODE_TEST,   32'h8000_0005, 1,  1'b0, '0},
      '{bovl_pkg::MODE_PUSH,   32'h8000_0003, 1,  1'b0, '0},
      '{bovl_pkg::MODE_DELETE, 32'h8000_0003, 1,  1'b0, '0},
      '{bovl_pkg::MODE_TEST,   32'h8000_0003, 1,  1'b0, '0},
      '{bovl_pkg::MODE_DELETE, 32'h8000_0003, 1,  1'b0, '0},
      '{bovl_pkg::MODE_DELETE, 32'h0000_0000, 1,  1'b0, '0},
      '{bovl_pkg::MODE_POP,    32'h0000_0000, 14, 1'b0, '0}
   };

   bounded_ordered_value_list_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_value        (req_value),
      .rsp_strobe       (rsp_strobe),
      .rsp_popped_value (rsp_popped_value),
      .rsp_found        (rsp_found),
      .rsp_status       (rsp_status),
      .rsp_length       (rsp_length)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // apply one item to the predicted list and return its result
   function automatic list_result_type apply_list_op(bovl_pkg::mode_type op,
                                                     logic [bovl_pkg::VALUE_W-1:0] val);
      list_result_type r;
      int              hit;
      r.popped_value = '0;
      r.found        = 1'b0;
      r.status       = bovl_pkg::STATUS_OK;
      hit            = -1;
      case (op)
         bovl_pkg::MODE_PUSH: begin
            if (list_model.size() >= LIST_DEPTH) r.status = bovl_pkg::STATUS_FULL;
            else list_model.push_front(val);
         end
         bovl_pkg::MODE_POP: begin
            if (list_model.size() == 0) r.status = bovl_pkg::STATUS_EMPTY;
            else r.popped_value = list_model.pop_front();
         end
         default: begin
            if (list_model.size() == 0) begin
               r.status = bovl_pkg::STATUS_EMPTY;
            end else begin
               // second entry to last first, the front entry only after them
               for (int i = 1; i < list_model.size(); i++)
                  if (hit < 0 && list_model[i] == val) hit = i;
               if (hit < 0 && list_model[0] == val) hit = 0;
               if (hit < 0) begin
                  r.status = bovl_pkg::STATUS_MISSING;
               end else begin
                  r.found = 1'b1;
                  if (op == bovl_pkg::MODE_DELETE) list_model.delete(hit);
               end
            end
         end
      endcase
      r.length = bovl_pkg::LENGTH_W'(list_model.size());
      return r;
   endfunction

   task automatic check_field(string name, logic [bovl_pkg::VALUE_W-1:0] want,
                              logic [bovl_pkg::VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // result checking first, then prediction of the item taken on this edge;
   // doing both in one block keeps the queue order independent of scheduling
   always @(posedge clock) begin
      list_result_type pred;
      list_result_type oldest;
      if (!reset) begin
         if (rsp_strobe) begin
            if (owed_results.size() == 0) begin
               $display("%0t ns: result with none expected, expected none, actual %h %b %0d %0d",
                        $time, rsp_popped_value, rsp_found, rsp_status, rsp_length);
               mismatches++;
            end else begin
               oldest = owed_results.pop_front();
               check_field("popped_value", oldest.popped_value, rsp_popped_value);
               check_field("found", bovl_pkg::VALUE_W'(oldest.found),
                           bovl_pkg::VALUE_W'(rsp_found));
               check_field("status", bovl_pkg::VALUE_W'(oldest.status),
                           bovl_pkg::VALUE_W'(rsp_status));
               check_field("length", bovl_pkg::VALUE_W'(oldest.length),
                           bovl_pkg::VALUE_W'(rsp_length));
            end
         end
         if (start && !busy) begin
            pred = apply_list_op(bovl_pkg::mode_type'(req_mode), req_value);
            owed_results.push_back(typed_valid ? typed_result : pred);
         end
         if (rsp_strobe || (start && !busy)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
      end
   end

   // put one item on the request ports and hold it until it is taken
   task automatic send_item(bovl_pkg::mode_type op, logic [bovl_pkg::VALUE_W-1:0] val,
                            bit typed, list_result_type want);
      @(negedge clock);
      req_mode     = op;
      req_value    = val;
      typed_valid  = typed;
      typed_result = want;
      start        = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // drop start for the gap given by n, with junk on the request fields
   task automatic idle_for(int n);
      if (n > 0) begin
         @(negedge clock);
         start     = 1'b0;
         req_mode  = bovl_pkg::MODE_W'($urandom_range(0, 3));
         req_value = $urandom;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // drop start and wait until every owed result has come back
   task automatic wait_all_returned();
      @(negedge clock);
      start = 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
   endtask

   // gap after an item: mostly none or short, a few long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // watchdog: gives up when nothing moves for too long
   initial begin
      while (stall_cycles < STALL_LIMIT) @(negedge clock);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int                           phase;
      int                           roll;
      bit                           no_gaps;
      bovl_pkg::mode_type           op;
      logic [bovl_pkg::VALUE_W-1:0] val;
      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = bovl_pkg::MODE_PUSH;
      req_value    = '0;
      typed_valid  = 1'b0;
      typed_result = '0;
      mismatches   = 0;
      stall_cycles = 0;
      phase        = 0;
      no_gaps      = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[r])
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            send_item(directed_rows[r].op, directed_rows[r].value + k,
                      directed_rows[r].typed, directed_rows[r].want);
            idle_for(pick_gap());
         end

      // random part in blocks of 60 items, each block leaning toward filling,
      // draining or neither, so that both full and empty lists keep coming up
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            phase   = $urandom_range(0, 2);
            no_gaps = ($urandom_range(0, 2) == 0);
         end
         // sender holds off until the unit has answered everything
         if (n == 300 || n == 600) wait_all_returned();
         roll = $urandom_range(0, 99);
         case (phase)
            0:       op = roll < 60 ? bovl_pkg::MODE_PUSH : roll < 70 ? bovl_pkg::MODE_POP :
                          roll < 85 ? bovl_pkg::MODE_DELETE : bovl_pkg::MODE_TEST;
            1:       op = roll < 20 ? bovl_pkg::MODE_PUSH : roll < 50 ? bovl_pkg::MODE_POP :
                          roll < 80 ? bovl_pkg::MODE_DELETE : bovl_pkg::MODE_TEST;
            default: op = roll < 30 ? bovl_pkg::MODE_PUSH : roll < 50 ? bovl_pkg::MODE_POP :
                          roll < 75 ? bovl_pkg::MODE_DELETE : bovl_pkg::MODE_TEST;
         endcase
         // values mostly ones already stored or a small pool, so searches hit
         roll = $urandom_range(0, 9);
         if (roll < 5 && list_model.size() != 0)
            val = list_model[$urandom_range(0, list_model.size() - 1)];
         else if (roll < 8)
            val = $urandom_range(0, 7);
         else
            val = $urandom;
         send_item(op, val, 1'b0, '0);
         if (!no_gaps) idle_for(pick_gap());
      end

      wait_all_returned();
      repeat (40) @(posedge clock);
      if (mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bovl_pkg.sv
hdl/bovl_store.sv
hdl/bovl_seq.sv
hdl/bounded_ordered_value_list_unit.sv
verif/tb_top.sv
